>>> src/dkte_pkg.sv
package dkte_pkg;

  // record tag bit positions
  localparam int unsigned TAG_KEY     = 0;
  localparam int unsigned TAG_MODE    = 1;
  localparam int unsigned TAG_FLAGS   = 2;
  localparam int unsigned TAG_VEHICLE = 3;
  localparam int unsigned TAG_WAVE    = 4;
  localparam int unsigned TAG_W       = 5;

  localparam logic [15:0] KEY_INTERVAL_RESET = 16'd64;
  localparam logic [15:0] COUNT_MAX          = 16'hFFFF;

  typedef struct packed {
    logic               track_start;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] rotation;
    logic [15:0]        vehicle_size;
    logic [15:0]        wave_size;
    logic [31:0]        time_stamp;
    logic [7:0]         icon_mode;
    logic [7:0]         frame_flags;
  } frame_t;

  typedef struct packed {
    logic [TAG_W-1:0]   record_tag;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
    logic signed [31:0] rot_value;
    logic [31:0]        time_value;
    logic [15:0]        vehicle_out;
    logic [15:0]        wave_out;
    logic [7:0]         mode_out;
    logic [7:0]         flags_out;
  } record_t;

  // history of the previous frame plus key bookkeeping
  typedef struct packed {
    logic [31:0] last_x;
    logic [31:0] last_y;
    logic [31:0] last_rot;
    logic [15:0] last_vehicle;
    logic [15:0] last_wave;
    logic [31:0] last_time;
    logic [7:0]  last_mode;
    logic [7:0]  last_flags;
    logic        have_previous;
    logic [15:0] deltas_since_key;
  } track_state_t;

  localparam track_state_t TRACK_STATE_RESET = '{
    last_x:           32'd0,
    last_y:           32'd0,
    last_rot:         32'd0,
    last_vehicle:     16'd1,
    last_wave:        16'd1,
    last_time:        32'd0,
    last_mode:        8'd0,
    last_flags:       8'd0,
    have_previous:    1'b0,
    deltas_since_key: 16'd0
  };

endpackage

>>> src/dkte_frame_if.sv
interface dkte_frame_if;
  logic               valid;
  logic               ready;
  logic               track_start;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] rotation;
  logic [15:0]        vehicle_size;
  logic [15:0]        wave_size;
  logic [31:0]        time_stamp;
  logic [7:0]         icon_mode;
  logic [7:0]         frame_flags;

  modport source (
    output valid, track_start, pos_x, pos_y, rotation, vehicle_size, wave_size,
           time_stamp, icon_mode, frame_flags,
    input  ready
  );

  modport sink (
    input  valid, track_start, pos_x, pos_y, rotation, vehicle_size, wave_size,
           time_stamp, icon_mode, frame_flags,
    output ready
  );
endinterface

>>> src/dkte_record_if.sv
interface dkte_record_if;
  logic               valid;
  logic               ready;
  logic [4:0]         record_tag;
  logic signed [31:0] x_value;
  logic signed [31:0] y_value;
  logic signed [31:0] rot_value;
  logic [31:0]        time_value;
  logic [15:0]        vehicle_out;
  logic [15:0]        wave_out;
  logic [7:0]         mode_out;
  logic [7:0]         flags_out;

  modport source (
    output valid, record_tag, x_value, y_value, rot_value, time_value,
           vehicle_out, wave_out, mode_out, flags_out,
    input  ready
  );

  modport sink (
    input  valid, record_tag, x_value, y_value, rot_value, time_value,
           vehicle_out, wave_out, mode_out, flags_out,
    output ready
  );
endinterface

>>> src/delta_keyframe_track_encoder.sv
// frame to record encoder: one record per frame
// path: an accepted frame waits in the input register, then its record is
//   registered in the result register; while records stall, frames wait
// throughput: one frame per cycle; history and record register update together
// reset: synchronous rst clears both stages, history to its start values and
//   key_interval to 64
module delta_keyframe_track_encoder (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_wdata,
  dkte_frame_if.sink    frames,
  dkte_record_if.source records
);
  import dkte_pkg::*;

  logic         in_valid;
  frame_t       in_frame;
  logic         out_valid;
  record_t      out_rec;
  track_state_t state;
  track_state_t state_next;
  record_t      rec_next;
  logic [15:0]  key_interval;
  logic         advance;

  // input stage moves on when the result register is free or draining
  assign advance      = in_valid && (!out_valid || records.ready);
  assign frames.ready = !in_valid || advance;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      key_interval <= KEY_INTERVAL_RESET;
    end else if (cfg_we) begin
      key_interval <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (frames.ready) begin
      in_valid <= frames.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frames.valid && frames.ready) begin
      in_frame.track_start  <= frames.track_start;
      in_frame.pos_x        <= frames.pos_x;
      in_frame.pos_y        <= frames.pos_y;
      in_frame.rotation     <= frames.rotation;
      in_frame.vehicle_size <= frames.vehicle_size;
      in_frame.wave_size    <= frames.wave_size;
      in_frame.time_stamp   <= frames.time_stamp;
      in_frame.icon_mode    <= frames.icon_mode;
      in_frame.frame_flags  <= frames.frame_flags;
    end
  end

  dkte_core u_core (
    .frame        (in_frame),
    .state        (state),
    .key_interval (key_interval),
    .rec          (rec_next),
    .state_next   (state_next)
  );

  // track history
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= TRACK_STATE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || records.ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_rec <= rec_next;
    end
  end

  assign records.valid       = out_valid;
  assign records.record_tag  = out_rec.record_tag;
  assign records.x_value     = out_rec.x_value;
  assign records.y_value     = out_rec.y_value;
  assign records.rot_value   = out_rec.rot_value;
  assign records.time_value  = out_rec.time_value;
  assign records.vehicle_out = out_rec.vehicle_out;
  assign records.wave_out    = out_rec.wave_out;
  assign records.mode_out    = out_rec.mode_out;
  assign records.flags_out   = out_rec.flags_out;

endmodule

>>> src/dkte_core.sv
module dkte_core (
  input  dkte_pkg::frame_t       frame,
  input  dkte_pkg::track_state_t state,
  input  logic [15:0]            key_interval,
  output dkte_pkg::record_t      rec,
  output dkte_pkg::track_state_t state_next
);
  import dkte_pkg::*;

  logic [32:0] dx;
  logic [32:0] dy;
  logic [32:0] dr;
  logic [32:0] dt;
  logic        fit_x;
  logic        fit_y;
  logic        fit_r;
  logic        time_bad;
  logic        key;
  logic        mode_chg;
  logic        flags_chg;
  logic        veh_chg;
  logic        wave_chg;

  // 33-bit signed deltas and the int16 range checks
  assign dx = {frame.pos_x[31], frame.pos_x} - {state.last_x[31], state.last_x};
  assign dy = {frame.pos_y[31], frame.pos_y} - {state.last_y[31], state.last_y};
  assign dr = {frame.rotation[31], frame.rotation} - {state.last_rot[31], state.last_rot};
  assign fit_x = (dx[32:15] == '0) || (dx[32:15] == '1);
  assign fit_y = (dy[32:15] == '0) || (dy[32:15] == '1);
  assign fit_r = (dr[32:15] == '0) || (dr[32:15] == '1);

  // time going backwards shows as a borrow, a long gap as high bits
  assign dt       = {1'b0, frame.time_stamp} - {1'b0, state.last_time};
  assign time_bad = dt[32] | (|dt[31:16]);

  assign key = frame.track_start | ~state.have_previous
             | (state.deltas_since_key >= key_interval)
             | ~fit_x | ~fit_y | ~fit_r | time_bad;

  assign mode_chg  = frame.icon_mode    != state.last_mode;
  assign flags_chg = frame.frame_flags  != state.last_flags;
  assign veh_chg   = frame.vehicle_size != state.last_vehicle;
  assign wave_chg  = frame.wave_size    != state.last_wave;

  // record selection
  always_comb begin
    rec = '0;
    if (key) begin
      rec.record_tag[TAG_KEY] = 1'b1;
      rec.x_value     = frame.pos_x;
      rec.y_value     = frame.pos_y;
      rec.rot_value   = frame.rotation;
      rec.time_value  = frame.time_stamp;
      rec.vehicle_out = frame.vehicle_size;
      rec.wave_out    = frame.wave_size;
      rec.mode_out    = frame.icon_mode;
      rec.flags_out   = frame.frame_flags;
    end else begin
      rec.record_tag[TAG_MODE]    = mode_chg;
      rec.record_tag[TAG_FLAGS]   = flags_chg;
      rec.record_tag[TAG_VEHICLE] = veh_chg;
      rec.record_tag[TAG_WAVE]    = wave_chg;
      rec.x_value     = dx[31:0];
      rec.y_value     = dy[31:0];
      rec.rot_value   = dr[31:0];
      rec.time_value  = dt[31:0];
      rec.vehicle_out = veh_chg   ? frame.vehicle_size : 16'd0;
      rec.wave_out    = wave_chg  ? frame.wave_size    : 16'd0;
      rec.mode_out    = mode_chg  ? frame.icon_mode    : 8'd0;
      rec.flags_out   = flags_chg ? frame.frame_flags  : 8'd0;
    end
  end

  // history update, counter saturates at its top value
  always_comb begin
    state_next.last_x        = frame.pos_x;
    state_next.last_y        = frame.pos_y;
    state_next.last_rot      = frame.rotation;
    state_next.last_vehicle  = frame.vehicle_size;
    state_next.last_wave     = frame.wave_size;
    state_next.last_time     = frame.time_stamp;
    state_next.last_mode     = frame.icon_mode;
    state_next.last_flags    = frame.frame_flags;
    state_next.have_previous = 1'b1;
    if (key) begin
      state_next.deltas_since_key = 16'd0;
    end else if (state.deltas_since_key != COUNT_MAX) begin
      state_next.deltas_since_key = state.deltas_since_key + 16'd1;
    end else begin
      state_next.deltas_since_key = state.deltas_since_key;
    end
  end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import dkte_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  dkte_frame_if  frame_bus ();
  dkte_record_if record_bus ();

  delta_keyframe_track_encoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .frames    (frame_bus.sink),
    .records   (record_bus.source)
  );

  // encoder history as the testbench sees it
  track_state_t hist;
  logic [15:0]  interval_setting;
  record_t      pending_records[$];
  frame_t       last_sent;
  int           mismatch_count = 0;
  int           cycle_count = 0;
  int           source_calm = 0;
  int           sink_calm = 0;

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // wait cycles per beat, with occasional stretches of back-to-back beats
  function automatic int draw_wait(ref int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 10);
  endfunction

  function automatic bit fits_int16(logic signed [32:0] d);
    return (&d[32:15]) || !(|d[32:15]);
  endfunction

  // expected record for one frame, advances the history
  function automatic record_t predict_record(frame_t f);
    record_t            r;
    logic signed [32:0] dx, dy, dr;
    logic [31:0]        dt;
    logic               key;
    r  = '0;
    dx = {f.pos_x[31], f.pos_x} - {hist.last_x[31], hist.last_x};
    dy = {f.pos_y[31], f.pos_y} - {hist.last_y[31], hist.last_y};
    dr = {f.rotation[31], f.rotation} - {hist.last_rot[31], hist.last_rot};
    dt = f.time_stamp - hist.last_time;
    key = f.track_start || !hist.have_previous ||
          (hist.deltas_since_key >= interval_setting);
    if (!fits_int16(dx) || !fits_int16(dy) || !fits_int16(dr) ||
        f.time_stamp < hist.last_time || dt > 32'd65535)
      key = 1'b1;
    if (key) begin
      r.record_tag[TAG_KEY] = 1'b1;
      r.x_value     = f.pos_x;
      r.y_value     = f.pos_y;
      r.rot_value   = f.rotation;
      r.time_value  = f.time_stamp;
      r.vehicle_out = f.vehicle_size;
      r.wave_out    = f.wave_size;
      r.mode_out    = f.icon_mode;
      r.flags_out   = f.frame_flags;
      hist.deltas_since_key = '0;
    end else begin
      r.record_tag[TAG_MODE]    = f.icon_mode != hist.last_mode;
      r.record_tag[TAG_FLAGS]   = f.frame_flags != hist.last_flags;
      r.record_tag[TAG_VEHICLE] = f.vehicle_size != hist.last_vehicle;
      r.record_tag[TAG_WAVE]    = f.wave_size != hist.last_wave;
      r.x_value    = dx[31:0];
      r.y_value    = dy[31:0];
      r.rot_value  = dr[31:0];
      r.time_value = dt;
      if (r.record_tag[TAG_VEHICLE]) r.vehicle_out = f.vehicle_size;
      if (r.record_tag[TAG_WAVE]) r.wave_out = f.wave_size;
      if (r.record_tag[TAG_MODE]) r.mode_out = f.icon_mode;
      if (r.record_tag[TAG_FLAGS]) r.flags_out = f.frame_flags;
      if (hist.deltas_since_key != COUNT_MAX) hist.deltas_since_key++;
    end
    hist.last_x        = f.pos_x;
    hist.last_y        = f.pos_y;
    hist.last_rot      = f.rotation;
    hist.last_time     = f.time_stamp;
    hist.last_vehicle  = f.vehicle_size;
    hist.last_wave     = f.wave_size;
    hist.last_mode     = f.icon_mode;
    hist.last_flags    = f.frame_flags;
    hist.have_previous = 1'b1;
    return r;
  endfunction

  // one frame beat: gap, then hold valid until accepted
  task automatic send_frame(input frame_t f);
    int gap;
    gap = draw_wait(source_calm);
    if (gap > 0) begin
      frame_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    frame_bus.valid        <= 1'b1;
    frame_bus.track_start  <= f.track_start;
    frame_bus.pos_x        <= f.pos_x;
    frame_bus.pos_y        <= f.pos_y;
    frame_bus.rotation     <= f.rotation;
    frame_bus.vehicle_size <= f.vehicle_size;
    frame_bus.wave_size    <= f.wave_size;
    frame_bus.time_stamp   <= f.time_stamp;
    frame_bus.icon_mode    <= f.icon_mode;
    frame_bus.frame_flags  <= f.frame_flags;
    @(posedge clk);
    while (frame_bus.ready !== 1'b1) @(posedge clk);
    pending_records = {pending_records, predict_record(f)};
    last_sent = f;
  endtask

  // register write once the encoder has drained
  task automatic write_interval(input logic [15:0] value);
    frame_bus.valid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    interval_setting = value;
  endtask

  function automatic frame_t make_frame(bit start, int x, int y, int rot,
                                        logic [15:0] veh, logic [15:0] wav,
                                        logic [31:0] stamp, logic [7:0] mode,
                                        logic [7:0] flg);
    frame_t f;
    f.track_start  = start;
    f.pos_x        = x;
    f.pos_y        = y;
    f.rotation     = rot;
    f.vehicle_size = veh;
    f.wave_size    = wav;
    f.time_stamp   = stamp;
    f.icon_mode    = mode;
    f.frame_flags  = flg;
    return f;
  endfunction

  function automatic frame_t random_frame();
    return make_frame(1'($urandom_range(0, 1)), $urandom(), $urandom(), $urandom(),
                      16'($urandom()), 16'($urandom()), $urandom(),
                      8'($urandom()), 8'($urandom()));
  endfunction

  // motion step: mostly small, some near the int16 edge, a few wild
  function automatic int motion_step();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return int'($urandom_range(0, 64)) - 32;
      6, 7:             return int'($urandom_range(0, 65535)) - 32768;
      8:                return int'($urandom_range(0, 65537)) - 32769;
      default:          return int'($urandom());
    endcase
  endfunction

  // time advance: mostly forward, sometimes at or past the limit, or back
  function automatic logic [31:0] time_step();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return $urandom_range(0, 2000);
      6:                return $urandom_range(65534, 65536);
      7:                return $urandom_range(60000, 70000);
      8:                return -$urandom_range(1, 1000);
      default:          return $urandom();
    endcase
  endfunction

  // next frame of a track, or the head of a new one
  function automatic frame_t track_frame(frame_t prev, bit head);
    frame_t f;
    f = random_frame();
    f.track_start = head;
    if (head) return f;
    f.pos_x      = prev.pos_x + motion_step();
    f.pos_y      = prev.pos_y + motion_step();
    f.rotation   = prev.rotation + motion_step();
    f.time_stamp = prev.time_stamp + time_step();
    if ($urandom_range(0, 3) != 0) f.vehicle_size = prev.vehicle_size;
    if ($urandom_range(0, 3) != 0) f.wave_size = prev.wave_size;
    if ($urandom_range(0, 3) != 0) f.icon_mode = prev.icon_mode;
    if ($urandom_range(0, 3) != 0) f.frame_flags = prev.frame_flags;
    return f;
  endfunction

  // key triggers, range edges, tag bits
  task automatic test_key_conditions();
    send_frame(make_frame(0, 0, 0, 0, 1, 1, 0, 0, 0));
    send_frame(make_frame(0, 32767, -32768, 0, 1, 1, 65535, 0, 0));
    send_frame(make_frame(0, 65535, -32768, 0, 1, 1, 65535, 0, 0));
    send_frame(make_frame(0, 65535, -65537, 0, 1, 1, 65535, 0, 0));
    send_frame(make_frame(0, 65535, -65537, 32768, 1, 1, 65535, 0, 0));
    send_frame(make_frame(0, 65535, -65537, 32768, 16'hFFFF, 0, 65535, 8'hFF, 8'hA5));
    send_frame(make_frame(0, 65535, -65537, 32768, 16'hFFFF, 0, 65534, 8'hFF, 8'hA5));
    send_frame(make_frame(0, 65535, -65537, 32768, 16'hFFFF, 0, 65534 + 65536,
                          8'hFF, 8'hA5));
    send_frame(make_frame(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 16'hFFFF,
                          32'hFFFF_FFFF, 0, 0));
    // 32-bit wrap would make this +1; on 33 bits it is far out
    send_frame(make_frame(0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0, 16'hFFFF,
                          32'hFFFF_FFFF, 0, 0));
    send_frame(make_frame(0, 32'h8000_0064, 32'h8000_0000, 32'h7FFF_FFFF, 0, 16'hFFFF,
                          32'hFFFF_FFFF, 0, 0));
    send_frame(make_frame(0, 32'h8000_0064, 32'h8000_0000, 32'h7FFF_FFFF, 0, 16'hFFFF,
                          0, 0, 0));
    send_frame(make_frame(1, 32'h8000_0064, 32'h8000_0000, 32'h7FFF_FFFF, 0, 16'hFFFF,
                          0, 0, 0));
    send_frame(make_frame(0, 32'h8000_0064, 32'h8000_0000, 32'h7FFF_FFFF, 0, 16'hFFFF,
                          1, 0, 8'h5A));
  endtask

  // quiet frames under zero, unit, maximum and lowered intervals
  task automatic test_interval_settings();
    logic [31:0] stamp;
    stamp = 100;
    write_interval(16'd0);
    repeat (3) begin
      stamp++;
      send_frame(make_frame(0, 7, 7, 7, 2, 2, stamp, 1, 1));
    end
    write_interval(16'd1);
    repeat (3) begin
      stamp++;
      send_frame(make_frame(0, 7, 7, 7, 2, 2, stamp, 1, 1));
    end
    write_interval(16'hFFFF);
    repeat (3) begin
      stamp++;
      send_frame(make_frame(0, 7, 7, 7, 2, 2, stamp, 1, 1));
    end
    // interval dropped below the running delta count forces a key
    write_interval(16'd2);
    repeat (2) begin
      stamp++;
      send_frame(make_frame(0, 7, 7, 7, 2, 2, stamp, 1, 1));
    end
  endtask

  // mostly well-formed tracks, a little noise
  task automatic test_random_tracks(input logic [15:0] interval, input int count);
    int sent;
    int track_len;
    frame_t f;
    sent = 0;
    write_interval(interval);
    while (sent < count) begin
      track_len = $urandom_range(1, 60);
      for (int k = 0; k < track_len && sent < count; k++) begin
        if ($urandom_range(0, 24) == 0)
          f = random_frame();
        else
          f = track_frame(last_sent, k == 0 && $urandom_range(0, 7) != 0);
        send_frame(f);
        sent++;
      end
    end
  endtask

  // record side: stall, then take one beat
  initial begin
    int w;
    record_bus.ready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      w = draw_wait(sink_calm);
      if (w > 0) begin
        record_bus.ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      record_bus.ready <= 1'b1;
      @(posedge clk);
      while (record_bus.valid !== 1'b1) @(posedge clk);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // compare each record beat with the oldest prediction
  always @(posedge clk) begin
    record_t want;
    if (!rst && record_bus.valid === 1'b1 && record_bus.ready === 1'b1) begin
      if (pending_records.size() == 0) begin
        $error("record beat with no frame outstanding");
        mismatch_count++;
      end else begin
        want = pending_records.pop_front();
        check_field("record_tag", 32'(want.record_tag), 32'(record_bus.record_tag));
        check_field("x_value", want.x_value, record_bus.x_value);
        check_field("y_value", want.y_value, record_bus.y_value);
        check_field("rot_value", want.rot_value, record_bus.rot_value);
        check_field("time_value", want.time_value, record_bus.time_value);
        check_field("vehicle_out", 32'(want.vehicle_out), 32'(record_bus.vehicle_out));
        check_field("wave_out", 32'(want.wave_out), 32'(record_bus.wave_out));
        check_field("mode_out", 32'(want.mode_out), 32'(record_bus.mode_out));
        check_field("flags_out", 32'(want.flags_out), 32'(record_bus.flags_out));
      end
    end
  end

  initial begin
    frame_bus.valid        = 1'b0;
    frame_bus.track_start  = 1'b0;
    frame_bus.pos_x        = '0;
    frame_bus.pos_y        = '0;
    frame_bus.rotation     = '0;
    frame_bus.vehicle_size = '0;
    frame_bus.wave_size    = '0;
    frame_bus.time_stamp   = '0;
    frame_bus.icon_mode    = '0;
    frame_bus.frame_flags  = '0;
    hist             = TRACK_STATE_RESET;
    interval_setting = KEY_INTERVAL_RESET;
    last_sent        = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_key_conditions();
    test_interval_settings();
    test_random_tracks(16'($urandom_range(2, 16)), 190);
    test_random_tracks(16'd0, 190);
    test_random_tracks(16'hFFFF, 190);
    test_random_tracks(16'd1, 190);
    test_random_tracks(16'($urandom_range(17, 300)), 190);

    // drain
    frame_bus.valid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> filelist.f
src/dkte_pkg.sv
src/dkte_frame_if.sv
src/dkte_record_if.sv
src/dkte_core.sv
src/delta_keyframe_track_encoder.sv
test/tb_top.sv
